// ----- hw/rtl/eip_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_pkg: shared types and constants of the entity id pool
// Field widths, operation and status codes, and the command word passed from
// the decoding front end to the execution back end.
// ----------------------------------------------------------------------------
package eip_pkg;

    // Field widths of the request and response words
    localparam int FUNC_W     = 2;
    localparam int ENTITY_W   = 8;
    localparam int COMP_W     = 6;
    localparam int SET_W      = 64;
    localparam int STATUS_W   = 2;

    // Mask storage is built from 32-bit words
    localparam int WORD_BITS  = 32;

    // Widest entity index the parameter range allows (4096 entities)
    localparam int ID_MAX_W   = 12;

    // Defaults for the top-level parameters
    localparam int DEF_ENTITIES   = 256;
    localparam int DEF_MASK_WORDS = 2;

    // Depth of the command queue between front and back
    localparam int Q_DEPTH    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_SETCLR  = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Decoded command: arg is the OR mask on allocate, the one-hot bit on
    // set/clear and the required set on query
    typedef struct packed {
        func_t               op;
        logic                ent_ok;
        logic [ID_MAX_W-1:0] ent;
        logic                turn_on;
        logic                arg_ok;
        logic [SET_W-1:0]    arg;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

endpackage
`default_nettype wire

// ----- hw/rtl/eip_cmd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_cmd_if: request channel of the entity id pool
// Valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface eip_cmd_if import eip_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ENTITY_W-1:0] entity;
    logic [COMP_W-1:0]   component;
    logic                turn_on;
    logic [SET_W-1:0]    component_set;

    modport source (
        output valid, func, entity, component, turn_on, component_set,
        input  ready
    );

    modport sink (
        input  valid, func, entity, component, turn_on, component_set,
        output ready
    );

endinterface
`default_nettype wire

// ----- hw/rtl/eip_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_rsp_if: response channel of the entity id pool
// Valid/ready handshake carrying one result word per operation.
// ----------------------------------------------------------------------------
interface eip_rsp_if import eip_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ENTITY_W-1:0] new_entity;
    logic                has_all;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, new_entity, has_all, status,
        input  ready
    );

    modport sink (
        input  valid, new_entity, has_all, status,
        output ready
    );

endinterface
`default_nettype wire

// ----- hw/rtl/eip_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_front: request decoder
// Accepts request words, range-checks entity and component, and builds the
// operand mask for the back end.
// ----------------------------------------------------------------------------
module eip_front import eip_pkg::*; #(
    parameter int ENTITIES   = DEF_ENTITIES,
    parameter int MASK_WORDS = DEF_MASK_WORDS
) (
    eip_cmd_if.sink    req,
    input  logic       clearing,
    input  logic       push_ready,
    output cmd_link_t  push
);

    localparam int MW    = WORD_BITS * MASK_WORDS;
    localparam int BIT_W = $clog2(MW);
    localparam logic [SET_W-1:0] VALID_MASK = SET_W'({MW{1'b1}});

    func_t            op;
    logic             ent_ok;
    logic             comp_ok;
    logic             set_ok;
    logic [SET_W-1:0] comp_bit;

    // Classify the word and check its ranges
    always_comb
    begin
        op       = func_t'(req.func);
        ent_ok   = ({{(32-ENTITY_W){1'b0}}, req.entity} < 32'(ENTITIES));
        comp_ok  = ({1'b0, req.component} < (COMP_W+1)'(MW));
        set_ok   = ((req.component_set & ~VALID_MASK) == '0);
        comp_bit = SET_W'(64'h1) << req.component[BIT_W-1:0];

        // Hold off requests during the post-reset sweep
        push.valid       = req.valid && !clearing;
        push.cmd.op      = op;
        push.cmd.ent_ok  = ent_ok;
        push.cmd.ent     = ID_MAX_W'(req.entity);
        push.cmd.turn_on = req.turn_on;

        unique case (op)
            FUNC_ALLOC:
            begin
                push.cmd.arg_ok = 1'b1;
                push.cmd.arg    = req.component_set & VALID_MASK;
            end
            FUNC_RELEASE:
            begin
                push.cmd.arg_ok = 1'b1;
                push.cmd.arg    = '0;
            end
            FUNC_SETCLR:
            begin
                push.cmd.arg_ok = comp_ok;
                push.cmd.arg    = comp_bit;
            end
            default:
            begin
                push.cmd.arg_ok = set_ok;
                push.cmd.arg    = req.component_set;
            end
        endcase
    end

    assign req.ready = push_ready && !clearing;

endmodule
`default_nettype wire

// ----- hw/rtl/eip_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_cmd_queue: decoupling queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module eip_cmd_queue import eip_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_link_t push,
    output logic      push_ready,
    output cmd_link_t head,
    input  logic      pop
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ----- hw/rtl/eip_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eip_back: execution engine
// Owns the free id FIFO and the component mask memory, runs one command as a
// mask read followed by a modify-write, and registers the response word.
// ----------------------------------------------------------------------------
module eip_back import eip_pkg::*; #(
    parameter int ENTITIES   = DEF_ENTITIES,
    parameter int MASK_WORDS = DEF_MASK_WORDS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_link_t  head,
    output logic       pop,
    output logic       clearing,
    eip_rsp_if.source  rsp
);

    localparam int ID_W  = $clog2(ENTITIES);
    localparam int CNT_W = $clog2(ENTITIES + 1);
    localparam int MW    = WORD_BITS * MASK_WORDS;
    localparam logic [ID_W-1:0]  LAST_ID  = ID_W'(ENTITIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTITIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg,      state_next;
    logic [ID_W-1:0]     clr_idx_reg,    clr_idx_next;
    logic [ID_W-1:0]     head_reg,       head_next;
    logic [ID_W-1:0]     tail_reg,       tail_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                wrapped_reg,    wrapped_next;
    cmd_t                cur_reg,        cur_next;
    logic [ID_W-1:0]     id_reg,         id_next;
    logic                out_valid_reg,  out_valid_next;
    logic [ENTITY_W-1:0] new_entity_reg, new_entity_next;
    logic                has_all_reg,    has_all_next;
    status_t             status_reg,     status_next;

    // Free id FIFO storage, read ahead at the next head slot
    logic [ID_W-1:0]     free_mem [ENTITIES];
    logic [ID_W-1:0]     free_q_reg;
    logic                free_byp_reg;
    logic [ID_W-1:0]     free_wdata_reg;
    logic                free_we;
    logic [ID_W-1:0]     free_wdata;

    // Component mask storage
    logic [MW-1:0]       mask_mem [ENTITIES];
    logic [MW-1:0]       mask_q_reg;
    logic                mask_we;
    logic [ID_W-1:0]     mask_waddr;
    logic [MW-1:0]       mask_wdata;
    logic [ID_W-1:0]     mask_raddr;

    logic [ID_W-1:0]     head_id;
    logic [ID_W-1:0]     head_ent;
    logic [ID_W-1:0]     cur_ent;
    logic [MW-1:0]       cur_arg;

    // Oldest free id: slot number until the head first wraps, then storage
    assign head_id  = wrapped_reg ? (free_byp_reg ? free_wdata_reg : free_q_reg) : head_reg;
    assign head_ent = head.cmd.ent[ID_W-1:0];
    assign cur_ent  = cur_reg.ent[ID_W-1:0];
    assign cur_arg  = cur_reg.arg[MW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        wrapped_next    = wrapped_reg;
        cur_next        = cur_reg;
        id_next         = id_reg;
        out_valid_next  = out_valid_reg;
        new_entity_next = new_entity_reg;
        has_all_next    = has_all_reg;
        status_next     = status_reg;
        pop             = 1'b0;
        free_we         = 1'b0;
        free_wdata      = cur_ent;
        mask_we         = 1'b0;
        mask_waddr      = cur_ent;
        mask_wdata      = '0;
        mask_raddr      = head_ent;

        // Drop the response once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one mask entry per cycle
                mask_we    = 1'b1;
                mask_waddr = clr_idx_reg;
                mask_wdata = '0;
                clr_idx_next = ID_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == LAST_ID)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // Read the mask of the target entity
                mask_raddr = (head.cmd.op == FUNC_ALLOC) ? head_id : head_ent;
                if (head.valid && (!out_valid_reg || rsp.ready))
                begin
                    pop        = 1'b1;
                    cur_next   = head.cmd;
                    id_next    = head_id;
                    state_next = ST_EXEC;
                end
            end

            default:
            begin
                // Modify, write back and present the result
                state_next      = ST_IDLE;
                out_valid_next  = 1'b1;
                new_entity_next = '0;
                has_all_next    = 1'b0;
                status_next     = STAT_OK;
                unique case (cur_reg.op)
                    FUNC_ALLOC:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            new_entity_next = ENTITY_W'(id_reg);
                            mask_we    = 1'b1;
                            mask_waddr = id_reg;
                            mask_wdata = mask_q_reg | cur_arg;
                            count_next = CNT_W'(count_reg - 1'b1);
                            if (head_reg == LAST_ID)
                            begin
                                head_next    = '0;
                                wrapped_next = 1'b1;
                            end
                            else
                            begin
                                head_next = ID_W'(head_reg + 1'b1);
                            end
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (cur_reg.ent_ok)
                        begin
                            free_we    = 1'b1;
                            free_wdata = cur_ent;
                            tail_next  = (tail_reg == LAST_ID) ? '0 : ID_W'(tail_reg + 1'b1);
                            count_next = CNT_W'(count_reg + 1'b1);
                            mask_we    = 1'b1;
                            mask_waddr = cur_ent;
                            mask_wdata = '0;
                        end
                    end
                    FUNC_SETCLR:
                    begin
                        if (cur_reg.ent_ok && cur_reg.arg_ok)
                        begin
                            mask_we    = 1'b1;
                            mask_waddr = cur_ent;
                            mask_wdata = cur_reg.turn_on ? (mask_q_reg | cur_arg)
                                                         : (mask_q_reg & ~cur_arg);
                        end
                    end
                    default:
                    begin
                        has_all_next = cur_reg.ent_ok && cur_reg.arg_ok &&
                                       ((mask_q_reg & cur_arg) == cur_arg);
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= FULL_CNT;
            wrapped_reg    <= 1'b0;
            cur_reg        <= '0;
            id_reg         <= '0;
            out_valid_reg  <= 1'b0;
            new_entity_reg <= '0;
            has_all_reg    <= 1'b0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            wrapped_reg    <= wrapped_next;
            cur_reg        <= cur_next;
            id_reg         <= id_next;
            out_valid_reg  <= out_valid_next;
            new_entity_reg <= new_entity_next;
            has_all_reg    <= has_all_next;
            status_reg     <= status_next;
        end
    end

    // Free id memory: push at the tail, prefetch the next head slot
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[tail_reg] <= free_wdata;
        end
        free_q_reg     <= free_mem[head_next];
        free_byp_reg   <= free_we && (tail_reg == head_next);
        free_wdata_reg <= free_wdata;
    end

    // Mask memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_q_reg <= mask_mem[mask_raddr];
    end

    assign clearing       = (state_reg == ST_CLEAR);
    assign rsp.valid      = out_valid_reg;
    assign rsp.new_entity = new_entity_reg;
    assign rsp.has_all    = has_all_reg;
    assign rsp.status     = status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("free count above pool size");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> head_reg == tail_reg)
        else $error("free queue pointers disagree with count");

    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> !out_valid_reg)
        else $error("execute cycle with response register occupied");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> out_valid_reg)
        else $error("execute cycle produced no response");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !pop)
        else $error("command taken during mask sweep");

endmodule
`default_nettype wire

// ----- hw/rtl/entity_id_pool_with_component_masks.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entity_id_pool_with_component_masks: entity id pool with component masks
// Free id FIFO plus one component bitmask per entity; allocate, release,
// set/clear a component bit and query a component set.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation word per handshake (func, entity, component,
//   turn_on, component_set); res returns exactly one result word per
//   operation (new_entity, has_all, status), in order.
//   A word is taken on cmd into a two-entry command queue; the back end then
//   handles each word as a mask memory read followed by a read-modify-write,
//   and pops the next word only after the last one is done and res has room.
//   After reset the mask memory is swept to zero, one entry a cycle, and
//   cmd.ready stays low throughout. The free queue starts full with ids 0 to
//   ENTITIES-1 in order.
//   If res is stalled, the result word holds in its output register and the
//   queue keeps taking words until both entries are full.
//   Allocate on an empty pool answers status 1; release into a full queue
//   answers status 2 and changes nothing.
// ----------------------------------------------------------------------------
module entity_id_pool_with_component_masks import eip_pkg::*; #(
    parameter int ENTITIES   = DEF_ENTITIES,
    parameter int MASK_WORDS = DEF_MASK_WORDS
) (
    input  logic       clk,
    input  logic       rst_n,
    eip_cmd_if.sink    cmd,
    eip_rsp_if.source  res
);

    cmd_link_t push_link;
    cmd_link_t queue_head;
    logic      push_ready;
    logic      pop;
    logic      clearing;

    // Decode requests
    eip_front #(
        .ENTITIES   (ENTITIES),
        .MASK_WORDS (MASK_WORDS)
    ) u_front (
        .req        (cmd),
        .clearing   (clearing),
        .push_ready (push_ready),
        .push       (push_link)
    );

    // Decouple decode from execution
    eip_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_link),
        .push_ready (push_ready),
        .head       (queue_head),
        .pop        (pop)
    );

    // Execute against the free FIFO and mask memory
    eip_back #(
        .ENTITIES   (ENTITIES),
        .MASK_WORDS (MASK_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (queue_head),
        .pop        (pop),
        .clearing   (clearing),
        .rsp        (res)
    );

endmodule
`default_nettype wire
